// ===== rtl/wait_for_graph_deadlock_detector_defines.svh =====
// assertion macros of the deadlock detector rtl
`ifndef WAIT_FOR_GRAPH_DEADLOCK_DETECTOR_DEFINES_SVH
`define WAIT_FOR_GRAPH_DEADLOCK_DETECTOR_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define WFG_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// implication checked in the same cycle
`define WFG_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// ===== rtl/wfg_pkg.sv =====
// types, codes and helpers of the wait-for graph deadlock detector
`default_nettype none
package wfg_pkg;

  typedef struct packed {
    logic [1:0]  mode;
    logic [21:0] process_id;
    logic [31:0] thread_id;
    logic [47:0] resource_addr;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] chain_depth;
  } out_item_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic [47:0] resource;
    logic [21:0] process;
    logic [31:0] thread;
  } entry_t;

  localparam int unsigned EntryBits = $bits(entry_t);

  localparam logic [1:0] MODE_WAIT    = 2'd0;
  localparam logic [1:0] MODE_ACQUIRE = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_DEADLOCK = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  localparam logic [9:0] DEPTH_MAX = 10'd1023;

  function automatic logic [9:0] depth_inc(input logic [9:0] d);
    return (d < DEPTH_MAX) ? d + 10'd1 : d;
  endfunction

  function automatic entry_t item_entry(input in_item_t it);
    entry_t e;
    e.resource = it.resource_addr;
    e.process  = it.process_id;
    e.thread   = it.thread_id;
    return e;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/wfg_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none
module wfg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/wfg_ctrl.sv =====
// table sequencer: append, compaction and chain walk over the table rams
`default_nettype none
`include "wait_for_graph_deadlock_detector_defines.svh"
module wfg_ctrl #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire wfg_pkg::in_item_t item,
  input  wire logic              out_free,
  output logic                   idle,
  output logic                   res_valid,
  output wfg_pkg::out_item_t     res
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_START, S_CLEAR, S_START_D, S_HSCAN, S_HSCAN_D,
    S_WSCAN, S_WSCAN_D, S_CMP, S_CMP_D, S_ACQ, S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  wfg_pkg::in_item_t item_r, item_nxt;
  logic [CW-1:0]     wcnt_r, wcnt_nxt, hcnt_r, hcnt_nxt;
  logic [CW-1:0]     i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [CW-1:0]     src_r, src_nxt, dst_r, dst_nxt;
  logic              cmp_held_r, cmp_held_nxt;
  logic [47:0]       res_r, res_nxt;
  logic [21:0]       hp_r, hp_nxt;
  logic [31:0]       ht_r, ht_nxt;
  logic [9:0]        depth_r, depth_nxt;
  logic [1:0]        status_r, status_nxt;

  logic                  w_we, h_we, m_we;
  logic [AW-1:0]         w_waddr, h_waddr, w_raddr, h_raddr, m_waddr, m_raddr;
  wfg_pkg::entry_t       w_wdata, h_wdata, w_rdata, h_rdata, cmp_data;
  logic [wfg_pkg::EntryBits-1:0] w_rbits, h_rbits;
  logic                  m_wdata, m_rdata;
  logic                  wait_hit;

  wfg_ram #(.WIDTH(wfg_pkg::EntryBits), .DEPTH(TABLE_ENTRIES)) u_wait_ram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rbits)
  );

  wfg_ram #(.WIDTH(wfg_pkg::EntryBits), .DEPTH(TABLE_ENTRIES)) u_held_ram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rbits)
  );

  // visited marks of the waiting entries, rewritten at every walk start
  wfg_ram #(.WIDTH(1), .DEPTH(TABLE_ENTRIES)) u_mark_ram (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  assign w_rdata  = wfg_pkg::entry_t'(w_rbits);
  assign h_rdata  = wfg_pkg::entry_t'(h_rbits);
  assign cmp_data = cmp_held_r ? h_rdata : w_rdata;
  assign m_raddr  = k_r[AW-1:0];
  assign wait_hit = (w_rdata.process == hp_r) && (w_rdata.thread == ht_r);

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE) && out_free;
  assign res.status      = status_r;
  assign res.chain_depth = depth_r;

  // ram port steering
  always_comb begin
    w_we    = 1'b0;
    h_we    = 1'b0;
    m_we    = 1'b0;
    w_waddr = wcnt_r[AW-1:0];
    h_waddr = hcnt_r[AW-1:0];
    m_waddr = src_r[AW-1:0];
    w_wdata = wfg_pkg::item_entry(item_r);
    h_wdata = wfg_pkg::item_entry(item_r);
    m_wdata = 1'b0;
    w_raddr = i_r[AW-1:0];
    h_raddr = j_r[AW-1:0];
    case (state_r)
      S_DISPATCH: begin
        w_we = (item_r.mode == wfg_pkg::MODE_WAIT) && (wcnt_r != FULL);
      end
      S_CLEAR: begin
        m_we    = 1'b1;
        m_wdata = (src_r == i_r);
      end
      S_WSCAN: w_raddr = k_r[AW-1:0];
      S_WSCAN_D: begin
        if (wait_hit && !m_rdata) begin
          m_we    = 1'b1;
          m_waddr = k_r[AW-1:0];
          m_wdata = 1'b1;
        end
      end
      S_CMP: begin
        w_raddr = src_r[AW-1:0];
        h_raddr = src_r[AW-1:0];
      end
      S_CMP_D: begin
        if (cmp_data != wfg_pkg::item_entry(item_r)) begin
          w_we    = !cmp_held_r;
          h_we    = cmp_held_r;
          w_waddr = dst_r[AW-1:0];
          h_waddr = dst_r[AW-1:0];
          w_wdata = cmp_data;
          h_wdata = cmp_data;
        end
      end
      S_ACQ: h_we = (hcnt_r != FULL);
      default: ;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    wcnt_nxt     = wcnt_r;
    hcnt_nxt     = hcnt_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    cmp_held_nxt = cmp_held_r;
    res_nxt      = res_r;
    hp_nxt       = hp_r;
    ht_nxt       = ht_r;
    depth_nxt    = depth_r;
    status_nxt   = status_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = item;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        status_nxt = wfg_pkg::STATUS_OK;
        depth_nxt  = '0;
        src_nxt    = '0;
        dst_nxt    = '0;
        case (item_r.mode)
          wfg_pkg::MODE_WAIT: begin
            if (wcnt_r == FULL) begin
              status_nxt = wfg_pkg::STATUS_FULL;
              state_nxt  = S_DONE;
            end else begin
              wcnt_nxt  = wcnt_r + CW'(1);
              i_nxt     = '0;
              state_nxt = S_START;
            end
          end
          wfg_pkg::MODE_ACQUIRE: begin
            cmp_held_nxt = 1'b0;
            state_nxt    = S_CMP;
          end
          wfg_pkg::MODE_RELEASE: begin
            cmp_held_nxt = 1'b1;
            state_nxt    = S_CMP;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_START: begin
        depth_nxt = '0;
        if (i_r == wcnt_r) begin
          state_nxt = S_DONE;
        end else begin
          src_nxt   = '0;
          state_nxt = S_CLEAR;
        end
      end
      // only the start entry stays marked
      S_CLEAR: begin
        src_nxt = src_r + CW'(1);
        if (src_r + CW'(1) == wcnt_r) begin
          state_nxt = S_START_D;
        end
      end
      S_START_D: begin
        res_nxt   = w_rdata.resource;
        j_nxt     = '0;
        state_nxt = S_HSCAN;
      end
      S_HSCAN: begin
        if (j_r == hcnt_r) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_START;
        end else begin
          state_nxt = S_HSCAN_D;
        end
      end
      S_HSCAN_D: begin
        if (h_rdata.resource == res_r) begin
          depth_nxt = wfg_pkg::depth_inc(depth_r);
          hp_nxt    = h_rdata.process;
          ht_nxt    = h_rdata.thread;
          k_nxt     = '0;
          state_nxt = S_WSCAN;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_HSCAN;
        end
      end
      S_WSCAN: begin
        if (k_r == wcnt_r) begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_HSCAN;
        end else begin
          state_nxt = S_WSCAN_D;
        end
      end
      S_WSCAN_D: begin
        if (wait_hit) begin
          depth_nxt = wfg_pkg::depth_inc(depth_r);
          if (m_rdata) begin
            status_nxt = wfg_pkg::STATUS_DEADLOCK;
            state_nxt  = S_DONE;
          end else begin
            res_nxt   = w_rdata.resource;
            j_nxt     = '0;
            state_nxt = S_HSCAN;
          end
        end else begin
          k_nxt     = k_r + CW'(1);
          state_nxt = S_WSCAN;
        end
      end
      S_CMP: begin
        if (src_r == (cmp_held_r ? hcnt_r : wcnt_r)) begin
          if (cmp_held_r) begin
            hcnt_nxt  = dst_r;
            state_nxt = S_DONE;
          end else begin
            wcnt_nxt  = dst_r;
            state_nxt = S_ACQ;
          end
        end else begin
          state_nxt = S_CMP_D;
        end
      end
      S_CMP_D: begin
        src_nxt = src_r + CW'(1);
        if (cmp_data != wfg_pkg::item_entry(item_r)) begin
          dst_nxt = dst_r + CW'(1);
        end
        state_nxt = S_CMP;
      end
      S_ACQ: begin
        if (hcnt_r == FULL) begin
          status_nxt = wfg_pkg::STATUS_FULL;
        end else begin
          hcnt_nxt = hcnt_r + CW'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wcnt_r   <= '0;
      hcnt_r   <= '0;
      status_r <= wfg_pkg::STATUS_OK;
      depth_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      wcnt_r   <= wcnt_nxt;
      hcnt_r   <= hcnt_nxt;
      status_r <= status_nxt;
      depth_r  <= depth_nxt;
    end
    item_r     <= item_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    cmp_held_r <= cmp_held_nxt;
    res_r      <= res_nxt;
    hp_r       <= hp_nxt;
    ht_r       <= ht_nxt;
  end

  `WFG_ASSERT(a_counts_bounded, (wcnt_r <= FULL) && (hcnt_r <= FULL), "table count overflow")
  `WFG_ASSERT_IMP(a_clear_in_range, state_r == S_CLEAR, src_r < wcnt_r, "mark clear past table end")
  `WFG_ASSERT_IMP(a_deadlock_depth, res_valid && (res.status == wfg_pkg::STATUS_DEADLOCK), res.chain_depth >= 10'd2, "deadlock with short chain")
  `WFG_ASSERT_IMP(a_ok_depth, res_valid && (res.status != wfg_pkg::STATUS_DEADLOCK), res.chain_depth == 10'd0, "depth without deadlock")

endmodule
`default_nettype wire

// ===== rtl/wait_for_graph_deadlock_detector.sv =====
// wait-for graph deadlock detector top level
//
// usage:
// - in_valid/in_stall/in_data carry one lock event (wait, acquired, released);
//   a transfer happens when in_valid is high and in_stall is low
// - out_valid/out_stall/out_data carry exactly one result per event: status
//   (ok, deadlock, table full) and the chain depth of a found deadlock
// - one event is worked on at a time; in_stall stays high until its result
//   is handed to the output register and stays low while the block is idle
// - acquired and released events compact a table through one ram read port,
//   entry by entry; an acquire then appends the event to the held table
// - a wait event walks from each waiting entry: it first resets the visited
//   marks, then scans the held and waiting tables entry by entry in every
//   walk step; a full waiting table gives table full without any walk
// - the output register holds a result while out_stall is high; the next
//   event may be taken meanwhile, its result waits inside until the
//   register frees
// - synchronous reset empties both tables and the output register; no
//   clearing pass, table entries are only read below their counts
`default_nettype none
module wait_for_graph_deadlock_detector #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire wfg_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output wfg_pkg::out_item_t      out_data
);

  logic               ctrl_idle;
  logic               res_valid;
  wfg_pkg::out_item_t res;
  logic               out_free;
  logic               out_valid_r, out_valid_nxt;
  wfg_pkg::out_item_t out_data_r, out_data_nxt;

  // the sequencer takes a new event only when idle
  assign in_stall = !ctrl_idle;

  // output register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  wfg_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_valid && ctrl_idle),
    .item     (in_data),
    .out_free (out_free),
    .idle     (ctrl_idle),
    .res_valid(res_valid),
    .res      (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench of the wait-for graph deadlock detector
`default_nettype none

// shadow copy of both lock tables, predicts one result per lock event
class lock_table_scoreboard;
  wfg_pkg::entry_t   held_q[$];
  wfg_pkg::entry_t   wait_q[$];
  wfg_pkg::out_item_t status_q[$];
  int unsigned       errors;
  int unsigned       table_limit;

  function new(int unsigned entries);
    table_limit = entries;
    errors      = 0;
  endfunction

  static function logic [9:0] depth_step(logic [9:0] d);
    return (d == 10'h3FF) ? d : d + 10'd1;
  endfunction

  // walk from every waiting entry, first walk that revisits an entry wins
  function bit walk_for_cycle(output logic [9:0] depth);
    bit          visited[$];
    bit          advanced;
    bit          cycle;
    logic [47:0] res;
    logic [9:0]  d;
    for (int i = 0; i < wait_q.size(); i++) begin
      res = wait_q[i].resource;
      d   = '0;
      visited.delete();
      for (int v = 0; v < wait_q.size(); v++) visited.push_back(1'b0);
      visited[i] = 1'b1;
      while (1) begin
        advanced = 1'b0;
        cycle    = 1'b0;
        for (int j = 0; j < held_q.size() && !advanced && !cycle; j++) begin
          if (held_q[j].resource != res) continue;
          d = depth_step(d);
          for (int k = 0; k < wait_q.size(); k++) begin
            if (wait_q[k].process == held_q[j].process &&
                wait_q[k].thread == held_q[j].thread) begin
              d = depth_step(d);
              if (visited[k]) cycle = 1'b1;
              else begin
                res        = wait_q[k].resource;
                visited[k] = 1'b1;
                advanced   = 1'b1;
              end
              break;
            end
          end
        end
        if (cycle) begin
          depth = d;
          return 1'b1;
        end
        if (!advanced) break;
      end
    end
    depth = '0;
    return 1'b0;
  endfunction

  static function void drop_matching(ref wfg_pkg::entry_t q[$], input wfg_pkg::entry_t e);
    wfg_pkg::entry_t kept[$];
    foreach (q[n]) if (q[n] != e) kept.push_back(q[n]);
    q = kept;
  endfunction

  function void note_event(wfg_pkg::in_item_t it);
    wfg_pkg::entry_t    e;
    wfg_pkg::out_item_t r;
    logic [9:0]         d;
    e.resource = it.resource_addr;
    e.process  = it.process_id;
    e.thread   = it.thread_id;
    r.status      = wfg_pkg::STATUS_OK;
    r.chain_depth = '0;
    case (it.mode)
      wfg_pkg::MODE_WAIT: begin
        if (wait_q.size() >= table_limit) r.status = wfg_pkg::STATUS_FULL;
        else begin
          wait_q.push_back(e);
          if (walk_for_cycle(d)) begin
            r.status      = wfg_pkg::STATUS_DEADLOCK;
            r.chain_depth = d;
          end
        end
      end
      wfg_pkg::MODE_ACQUIRE: begin
        drop_matching(wait_q, e);
        if (held_q.size() >= table_limit) r.status = wfg_pkg::STATUS_FULL;
        else held_q.push_back(e);
      end
      wfg_pkg::MODE_RELEASE: drop_matching(held_q, e);
      default: ;
    endcase
    status_q.push_back(r);
  endfunction

  function void check_result(wfg_pkg::out_item_t got);
    wfg_pkg::out_item_t want;
    if (status_q.size() == 0) begin
      $display("%0t: unexpected result status=%0d depth=%0d", $time, got.status,
               got.chain_depth);
      errors++;
      return;
    end
    want = status_q.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status mismatch expected %0d actual %0d", $time, want.status,
               got.status);
      errors++;
    end
    if (got.chain_depth !== want.chain_depth) begin
      $display("%0t: chain_depth mismatch expected %0d actual %0d", $time,
               want.chain_depth, got.chain_depth);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int unsigned  ENTRIES     = 64;
  localparam logic [1:0]   MODE_UNUSED = 2'd3;
  // keep tables small in the random part so each walk stays short
  localparam int unsigned  RAND_CAP    = 12;
  localparam int unsigned  RAND_ITEMS  = 340;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  wfg_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  wfg_pkg::out_item_t out_data;

  lock_table_scoreboard lock_sb = new(ENTRIES);

  // small pools of owners and resources so that holders and waiters collide
  logic [21:0] proc_pool[4];
  logic [31:0] thr_pool[3];
  logic [47:0] res_pool[6];

  int unsigned rx_cycle  = 0;
  bit          no_gaps   = 1'b0;

  always #1 clk = ~clk;

  wait_for_graph_deadlock_detector #(.TABLE_ENTRIES(ENTRIES)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // result side: random stalls, one long hold-off that fills the block up,
  // then a long stretch with no stalls at all
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle >= 3000 && rx_cycle < 3400) begin
      out_stall <= 1'b1;
    end else if (rx_cycle >= 6000 && rx_cycle < 11000) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 28);
    end
  end

  // every accepted result goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) lock_sb.check_result(out_data);
  end

  // offer one lock event and hold it until the transfer
  task automatic send_event(input wfg_pkg::in_item_t it);
    if (!no_gaps && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    lock_sb.note_event(it);
  endtask

  function automatic wfg_pkg::in_item_t make_event(logic [1:0] m, logic [21:0] p,
                                                   logic [31:0] t, logic [47:0] r);
    wfg_pkg::in_item_t it;
    it.mode          = m;
    it.process_id    = p;
    it.thread_id     = t;
    it.resource_addr = r;
    return it;
  endfunction

  function automatic wfg_pkg::in_item_t pool_event(logic [1:0] m);
    return make_event(m, proc_pool[$urandom_range(3)], thr_pool[$urandom_range(2)],
                      res_pool[$urandom_range(5)]);
  endfunction

  function automatic wfg_pkg::in_item_t entry_event(logic [1:0] m, wfg_pkg::entry_t e);
    return make_event(m, e.process, e.thread, e.resource);
  endfunction

  // mostly plausible lock traffic on pooled owners, some raw noise
  function automatic wfg_pkg::in_item_t random_event();
    wfg_pkg::in_item_t it;
    int unsigned       pick;
    pick = $urandom_range(99);
    if (pick < 6) begin
      it = make_event(2'($urandom_range(3)), 22'($urandom), $urandom,
                      48'({$urandom, $urandom}));
    end else if (pick < 40) begin
      it = pool_event(wfg_pkg::MODE_WAIT);
    end else if (pick < 70) begin
      if (lock_sb.wait_q.size() > 0 && $urandom_range(99) < 80)
        it = entry_event(wfg_pkg::MODE_ACQUIRE,
                         lock_sb.wait_q[$urandom_range(lock_sb.wait_q.size() - 1)]);
      else
        it = pool_event(wfg_pkg::MODE_ACQUIRE);
    end else if (pick < 95) begin
      if (lock_sb.held_q.size() > 0 && $urandom_range(99) < 85)
        it = entry_event(wfg_pkg::MODE_RELEASE,
                         lock_sb.held_q[$urandom_range(lock_sb.held_q.size() - 1)]);
      else
        it = pool_event(wfg_pkg::MODE_RELEASE);
    end else begin
      it = pool_event(MODE_UNUSED);
    end
    // bound table growth: a full-ish table turns into a removal
    if (it.mode == wfg_pkg::MODE_WAIT && lock_sb.wait_q.size() >= RAND_CAP)
      it = entry_event(wfg_pkg::MODE_ACQUIRE, lock_sb.wait_q[0]);
    if (it.mode == wfg_pkg::MODE_ACQUIRE && lock_sb.held_q.size() >= RAND_CAP)
      it = entry_event(wfg_pkg::MODE_RELEASE, lock_sb.held_q[0]);
    return it;
  endfunction

  // empty both tables: acquire every waiter, then release every holder
  task automatic drain_tables();
    wfg_pkg::entry_t snap[$];
    snap = lock_sb.wait_q;
    foreach (snap[n]) send_event(entry_event(wfg_pkg::MODE_ACQUIRE, snap[n]));
    snap = lock_sb.held_q;
    foreach (snap[n]) send_event(entry_event(wfg_pkg::MODE_RELEASE, snap[n]));
  endtask

  initial begin
    wfg_pkg::entry_t fill[$];
    wfg_pkg::entry_t e;
    proc_pool[0] = '0;
    proc_pool[1] = '1;
    proc_pool[2] = 22'($urandom);
    proc_pool[3] = 22'($urandom);
    thr_pool[0]  = '0;
    thr_pool[1]  = '1;
    thr_pool[2]  = $urandom;
    res_pool[0]  = '0;
    res_pool[1]  = '1;
    for (int n = 2; n < 6; n++) res_pool[n] = 48'({$urandom, $urandom});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // two owners each hold what the other waits for: a two-party deadlock
    send_event(make_event(wfg_pkg::MODE_ACQUIRE, proc_pool[0], thr_pool[0], res_pool[0]));
    send_event(make_event(wfg_pkg::MODE_ACQUIRE, proc_pool[1], thr_pool[1], res_pool[1]));
    send_event(make_event(wfg_pkg::MODE_WAIT, proc_pool[0], thr_pool[0], res_pool[1]));
    send_event(make_event(wfg_pkg::MODE_WAIT, proc_pool[1], thr_pool[1], res_pool[0]));
    // third owner joins the chain, a holder without a waiting entry
    send_event(make_event(wfg_pkg::MODE_ACQUIRE, proc_pool[2], thr_pool[2], res_pool[2]));
    send_event(make_event(wfg_pkg::MODE_WAIT, proc_pool[2], thr_pool[1], res_pool[2]));
    // release of something never held, unused mode, all-ones and all-zero fields
    send_event(make_event(wfg_pkg::MODE_RELEASE, proc_pool[3], thr_pool[2], res_pool[3]));
    send_event(make_event(MODE_UNUSED, '1, '1, '1));
    send_event(make_event(MODE_UNUSED, '0, '0, '0));
    send_event(make_event(wfg_pkg::MODE_WAIT, '1, '1, '1));
    send_event(make_event(wfg_pkg::MODE_ACQUIRE, '1, '1, '1));
    send_event(make_event(wfg_pkg::MODE_RELEASE, '1, '1, '1));
    // acquire with no waiting entry and duplicate holders
    send_event(make_event(wfg_pkg::MODE_ACQUIRE, proc_pool[3], thr_pool[0], res_pool[3]));
    send_event(make_event(wfg_pkg::MODE_ACQUIRE, proc_pool[3], thr_pool[0], res_pool[3]));
    send_event(make_event(wfg_pkg::MODE_RELEASE, proc_pool[3], thr_pool[0], res_pool[3]));
    drain_tables();

    // random traffic, with a long run of back-to-back offers in the middle
    for (int n = 0; n < RAND_ITEMS; n++) begin
      no_gaps = (n >= 200 && n < 320);
      send_event(random_event());
    end
    no_gaps = 1'b0;
    drain_tables();

    // fill the waiting table past its end with distinct entries
    for (int n = 0; n <= ENTRIES; n++) begin
      e.process  = n[21:0];
      e.thread   = $urandom;
      e.resource = 48'({$urandom, $urandom});
      fill.push_back(e);
      send_event(entry_event(wfg_pkg::MODE_WAIT, e));
    end
    // move them all to the held table, the last one finds it full
    foreach (fill[n]) send_event(entry_event(wfg_pkg::MODE_ACQUIRE, fill[n]));
    send_event(entry_event(wfg_pkg::MODE_WAIT, fill[0]));
    send_event(entry_event(wfg_pkg::MODE_ACQUIRE, fill[1]));
    drain_tables();

    in_valid <= 1'b0;
    while (lock_sb.status_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (lock_sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// ===== wait_for_graph_deadlock_detector.f =====
+incdir+rtl
rtl/wfg_pkg.sv
rtl/wfg_ram.sv
rtl/wfg_ctrl.sv
rtl/wait_for_graph_deadlock_detector.sv
tb/sv/tb_top.sv
